>>> rtl/tci_pkg.sv
package tci_pkg;

    localparam int COORD_W    = 16;  // input coordinate width
    localparam int RAD_W      = 15;  // radius width
    localparam int DIFF_W     = 17;  // coordinate difference
    localparam int PROD_W     = 34;  // product of two differences
    localparam int SUM_W      = 35;  // sum or difference of two products
    localparam int MAG_W      = 34;  // nonnegative sums and magnitudes
    localparam int RSQ_W      = 30;  // radius squared
    localparam int HALF_W     = 32;  // cross magnitude that still gets squared
    localparam int WIDE_W     = 64;  // squared cross and radius^2 * length^2
    localparam int PIPE_DEPTH = 6;   // register stages from start to done

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic        [RSQ_W-1:0]  rsq_t;
    typedef logic        [HALF_W-1:0] half_t;
    typedef logic        [WIDE_W-1:0] wide_t;

    // Per-edge verdicts handed from an edge unit to the top level.
    typedef struct packed {
        logic vtx_hit;   // start vertex strictly inside the circle
        logic tri_neg;   // center on the negative side of the edge
        logic tri_pos;   // center on the positive side of the edge
        logic seg_near;  // edge segment within the radius
    } edge_flags_t;

endpackage

>>> rtl/tci_edge.sv
module tci_edge
    import tci_pkg::*;
(
    input  logic        clk,
    input  diff_t       dx,
    input  diff_t       dy,
    input  diff_t       esx,
    input  diff_t       esy,
    input  diff_t       etx,
    input  diff_t       ety,
    input  rsq_t        r2,
    input  mag_t        dist_end,
    output mag_t        dist_start,
    output edge_flags_t flags
);

    // Stage 2: products.
    prod_t p_esx2_reg, p_esy2_reg;
    prod_t p_tri0_reg, p_tri1_reg;
    prod_t p_dot0_reg, p_dot1_reg;
    prod_t p_len0_reg, p_len1_reg;
    prod_t p_cr0_reg, p_cr1_reg;

    always_ff @(posedge clk)
    begin
        p_esx2_reg <= esx * esx;
        p_esy2_reg <= esy * esy;
        p_tri0_reg <= dx * ety;
        p_tri1_reg <= dy * etx;
        p_dot0_reg <= dx * esx;
        p_dot1_reg <= dy * esy;
        p_len0_reg <= dx * dx;
        p_len1_reg <= dy * dy;
        p_cr0_reg  <= dx * esy;
        p_cr1_reg  <= dy * esx;
    end

    // Stage 3: sums.
    sum_t dist_sum, len_sum;
    sum_t tri_next, dot_next, cr_next;
    mag_t dist_s_reg, len2_reg;
    sum_t tri_reg, dot_reg, cr_reg;

    always_comb
    begin
        dist_sum = SUM_W'(p_esx2_reg) + SUM_W'(p_esy2_reg);
        len_sum  = SUM_W'(p_len0_reg) + SUM_W'(p_len1_reg);
        tri_next = SUM_W'(p_tri0_reg) - SUM_W'(p_tri1_reg);
        dot_next = SUM_W'(p_dot0_reg) + SUM_W'(p_dot1_reg);
        cr_next  = SUM_W'(p_cr0_reg) - SUM_W'(p_cr1_reg);
    end

    always_ff @(posedge clk)
    begin
        dist_s_reg <= dist_sum[MAG_W-1:0];
        len2_reg   <= len_sum[MAG_W-1:0];
        tri_reg    <= tri_next;
        dot_reg    <= dot_next;
        cr_reg     <= cr_next;
    end

    assign dist_start = dist_s_reg;

    // Stage 4: clamp decisions, endpoint distances and cross magnitude.
    logic dot_le0, dot_ge_len;
    sum_t acr;
    logic vtx_s4_reg, neg_s4_reg, pos_s4_reg;
    logic clamped_s4_reg, end_near_s4_reg, acr_big_s4_reg;
    half_t acr_lo_reg;
    rsq_t r2_s4_reg;
    mag_t len2_s4_reg;

    always_comb
    begin
        dot_le0    = (dot_reg <= 0);
        dot_ge_len = (dot_reg >= $signed({1'b0, len2_reg}));
        acr        = cr_reg[SUM_W-1] ? -cr_reg : cr_reg;
    end

    always_ff @(posedge clk)
    begin
        vtx_s4_reg      <= (dist_s_reg < MAG_W'(r2));
        neg_s4_reg      <= (tri_reg < 0);
        pos_s4_reg      <= (tri_reg > 0);
        clamped_s4_reg  <= dot_le0 || dot_ge_len;
        // A projection before the start uses the start point, else the end point.
        end_near_s4_reg <= dot_le0 ? (dist_s_reg <= MAG_W'(r2))
                                   : (dist_end <= MAG_W'(r2));
        acr_big_s4_reg  <= |acr[MAG_W-1:HALF_W];
        acr_lo_reg      <= acr[HALF_W-1:0];
        r2_s4_reg       <= r2;
        len2_s4_reg     <= len2_reg;
    end

    // Stage 5: squared cross against radius^2 times squared length.
    wide_t sq_reg, rl_reg;
    logic vtx_s5_reg, neg_s5_reg, pos_s5_reg;
    logic clamped_s5_reg, end_near_s5_reg, acr_big_s5_reg;

    always_ff @(posedge clk)
    begin
        sq_reg          <= WIDE_W'(acr_lo_reg) * WIDE_W'(acr_lo_reg);
        rl_reg          <= WIDE_W'(r2_s4_reg) * WIDE_W'(len2_s4_reg);
        vtx_s5_reg      <= vtx_s4_reg;
        neg_s5_reg      <= neg_s4_reg;
        pos_s5_reg      <= pos_s4_reg;
        clamped_s5_reg  <= clamped_s4_reg;
        end_near_s5_reg <= end_near_s4_reg;
        acr_big_s5_reg  <= acr_big_s4_reg;
    end

    // A cross magnitude of 2^32 or more always lies beyond the radius.
    always_comb
    begin
        flags.vtx_hit  = vtx_s5_reg;
        flags.tri_neg  = neg_s5_reg;
        flags.tri_pos  = pos_s5_reg;
        flags.seg_near = clamped_s5_reg ? end_near_s5_reg
                                        : (!acr_big_s5_reg && (sq_reg <= rl_reg));
    end

endmodule

>>> rtl/triangle_circle_intersect.sv
// Triangle versus circle intersection test. Raise start for one cycle with a
// triangle and a circle on the input ports; the verdict appears on hit together
// with a one-cycle done strobe once the item leaves the last stage. The block is a six-stage
// pipeline built around one edge unit per triangle edge (about ten 17x17
// multipliers each, plus the wide squared-cross and radius-times-length
// products), so it takes a new item in every cycle and busy stays low. There is
// no back-pressure: every transfer on the result side happens in the done cycle.
module triangle_circle_intersect
    import tci_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] vertex_a_x,
    input  logic signed [COORD_W-1:0] vertex_a_y,
    input  logic signed [COORD_W-1:0] vertex_b_x,
    input  logic signed [COORD_W-1:0] vertex_b_y,
    input  logic signed [COORD_W-1:0] vertex_c_x,
    input  logic signed [COORD_W-1:0] vertex_c_y,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic        [RAD_W-1:0]   radius,
    output logic                      done,
    output logic                      hit
);

    logic accept;
    logic [PIPE_DEPTH-1:0] valid_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // Stage 1: edge vectors and center offsets from each vertex.
    diff_t d_ab_x_reg, d_ab_y_reg, d_bc_x_reg, d_bc_y_reg, d_ca_x_reg, d_ca_y_reg;
    diff_t e_a_x_reg, e_a_y_reg, e_b_x_reg, e_b_y_reg, e_c_x_reg, e_c_y_reg;
    logic [RAD_W-1:0] r_s1_reg;

    always_ff @(posedge clk)
    begin
        d_ab_x_reg <= DIFF_W'(vertex_b_x) - DIFF_W'(vertex_a_x);
        d_ab_y_reg <= DIFF_W'(vertex_b_y) - DIFF_W'(vertex_a_y);
        d_bc_x_reg <= DIFF_W'(vertex_c_x) - DIFF_W'(vertex_b_x);
        d_bc_y_reg <= DIFF_W'(vertex_c_y) - DIFF_W'(vertex_b_y);
        d_ca_x_reg <= DIFF_W'(vertex_a_x) - DIFF_W'(vertex_c_x);
        d_ca_y_reg <= DIFF_W'(vertex_a_y) - DIFF_W'(vertex_c_y);
        e_a_x_reg  <= DIFF_W'(center_x) - DIFF_W'(vertex_a_x);
        e_a_y_reg  <= DIFF_W'(center_y) - DIFF_W'(vertex_a_y);
        e_b_x_reg  <= DIFF_W'(center_x) - DIFF_W'(vertex_b_x);
        e_b_y_reg  <= DIFF_W'(center_y) - DIFF_W'(vertex_b_y);
        e_c_x_reg  <= DIFF_W'(center_x) - DIFF_W'(vertex_c_x);
        e_c_y_reg  <= DIFF_W'(center_y) - DIFF_W'(vertex_c_y);
        r_s1_reg   <= radius;
    end

    // Radius squared, lined up with the edge units' third stage.
    rsq_t r2_s2_reg, r2_s3_reg;

    always_ff @(posedge clk)
    begin
        r2_s2_reg <= RSQ_W'(r_s1_reg) * RSQ_W'(r_s1_reg);
        r2_s3_reg <= r2_s2_reg;
    end

    // Each vertex starts exactly one edge, so an edge's end distance comes from
    // the next edge unit.
    mag_t        dist_a, dist_b, dist_c;
    edge_flags_t flags_ab, flags_bc, flags_ca;

    tci_edge u_edge_ab (
        .clk        (clk),
        .dx         (d_ab_x_reg),
        .dy         (d_ab_y_reg),
        .esx        (e_a_x_reg),
        .esy        (e_a_y_reg),
        .etx        (e_b_x_reg),
        .ety        (e_b_y_reg),
        .r2         (r2_s3_reg),
        .dist_end   (dist_b),
        .dist_start (dist_a),
        .flags      (flags_ab)
    );

    tci_edge u_edge_bc (
        .clk        (clk),
        .dx         (d_bc_x_reg),
        .dy         (d_bc_y_reg),
        .esx        (e_b_x_reg),
        .esy        (e_b_y_reg),
        .etx        (e_c_x_reg),
        .ety        (e_c_y_reg),
        .r2         (r2_s3_reg),
        .dist_end   (dist_c),
        .dist_start (dist_b),
        .flags      (flags_bc)
    );

    tci_edge u_edge_ca (
        .clk        (clk),
        .dx         (d_ca_x_reg),
        .dy         (d_ca_y_reg),
        .esx        (e_c_x_reg),
        .esy        (e_c_y_reg),
        .etx        (e_a_x_reg),
        .ety        (e_a_y_reg),
        .r2         (r2_s3_reg),
        .dist_end   (dist_a),
        .dist_start (dist_c),
        .flags      (flags_ca)
    );

    // The center is inside or on the triangle unless it sees edges of both
    // signs; a center that sees no sign at all, as with coincident vertices, counts as inside.
    logic any_neg, any_pos, hit_next, hit_reg;

    always_comb
    begin
        any_neg  = flags_ab.tri_neg || flags_bc.tri_neg || flags_ca.tri_neg;
        any_pos  = flags_ab.tri_pos || flags_bc.tri_pos || flags_ca.tri_pos;
        hit_next = flags_ab.vtx_hit || flags_bc.vtx_hit || flags_ca.vtx_hit
                || !(any_neg && any_pos)
                || flags_ab.seg_near || flags_bc.seg_near || flags_ca.seg_near;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit  = hit_reg;
    assign done = valid_reg[PIPE_DEPTH-1];

    // Every accepted item comes out after the full pipeline depth.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_DEPTH done)
        else $error("accepted item did not produce done after the pipeline depth");

    // No done strobe without a matching start.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("done without a matching start");

endmodule

>>> verif/tci_checker.sv
module tci_checker
    import tci_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [COORD_W-1:0] vertex_a_x,
    input  logic signed [COORD_W-1:0] vertex_a_y,
    input  logic signed [COORD_W-1:0] vertex_b_x,
    input  logic signed [COORD_W-1:0] vertex_b_y,
    input  logic signed [COORD_W-1:0] vertex_c_x,
    input  logic signed [COORD_W-1:0] vertex_c_y,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic        [RAD_W-1:0]   radius,
    input  logic                      done,
    input  logic                      hit,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    bit expected_hits[$];
    bit next_hit;
    int mismatches = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    // Cross product of (p - r) and (q - r).
    function automatic longint edge_cross(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
        return (px - rx) * (qy - ry) - (qx - rx) * (py - ry);
    endfunction

    function automatic bit segment_within(longint sx, longint sy, longint tx, longint ty,
                                          longint cx, longint cy, longint r2);
        longint dx, dy, ex, ey, dot, len2, cr;
        longint unsigned acr;
        dx   = tx - sx;
        dy   = ty - sy;
        ex   = cx - sx;
        ey   = cy - sy;
        dot  = dx * ex + dy * ey;
        len2 = dx * dx + dy * dy;
        if (dot <= 0)
            return sq_dist(cx, cy, sx, sy) <= r2;
        if (dot >= len2)
            return sq_dist(cx, cy, tx, ty) <= r2;
        cr  = dx * ey - dy * ex;
        acr = (cr < 0) ? longint'(-cr) : longint'(cr);
        // A cross this large squares past anything the right side can reach.
        if (acr >= 64'h1_0000_0000)
            return 1'b0;
        return acr * acr <= longint'(unsigned'(r2)) * longint'(unsigned'(len2));
    endfunction

    function automatic bit tri_circle_hit(longint ax, longint ay, longint bx, longint by,
                                          longint qx, longint qy, longint cx, longint cy,
                                          longint r);
        longint r2, d1, d2, d3;
        bit neg, pos;
        r2 = r * r;
        if (sq_dist(ax, ay, cx, cy) < r2 || sq_dist(bx, by, cx, cy) < r2 ||
            sq_dist(qx, qy, cx, cy) < r2)
            return 1'b1;
        d1  = edge_cross(cx, cy, ax, ay, bx, by);
        d2  = edge_cross(cx, cy, bx, by, qx, qy);
        d3  = edge_cross(cx, cy, qx, qy, ax, ay);
        neg = d1 < 0 || d2 < 0 || d3 < 0;
        pos = d1 > 0 || d2 > 0 || d3 > 0;
        // With all crosses zero, as for coincident vertices, the center counts as contained.
        if (!(neg && pos))
            return 1'b1;
        return segment_within(ax, ay, bx, by, cx, cy, r2) ||
               segment_within(bx, by, qx, qy, cx, cy, r2) ||
               segment_within(qx, qy, ax, ay, cx, cy, r2);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("hit: result transfer with no query outstanding, actual %0b", hit);
                    mismatches++;
                end
                else
                begin
                    next_hit = expected_hits.pop_front();
                    if (hit !== next_hit)
                    begin
                        $error("hit: expected %0b, actual %0b", next_hit, hit);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_hits.push_back(tri_circle_hit(
                    longint'(vertex_a_x), longint'(vertex_a_y),
                    longint'(vertex_b_x), longint'(vertex_b_y),
                    longint'(vertex_c_x), longint'(vertex_c_y),
                    longint'(center_x), longint'(center_y), longint'(radius)));
            fail_count <= mismatches;
            pending    <= expected_hits.size();
        end
    end

endmodule

>>> verif/tb_triangle_circle_intersect.sv
module tb_triangle_circle_intersect
    import tci_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM     = 450;
    localparam int NUM_PHASES     = 4;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = PIPE_DEPTH + 8;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, ox, oy;
        logic        [RAD_W-1:0]   r;
    } query_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
    logic signed [COORD_W-1:0] vertex_c_x, vertex_c_y, center_x, center_y;
    logic        [RAD_W-1:0]   radius;
    logic                      done;
    logic                      hit;
    int                        fail_count;
    int                        pending;
    int                        cycle_count = 0;
    int                        idle_pct    = 0;

    triangle_circle_intersect i_dut (.*);

    tci_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("FAIL triangle_circle_intersect");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] to_coord(int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic int sym(int s);
        return int'($urandom_range(2 * s)) - s;
    endfunction

    function automatic query_t make_query(int ax, int ay, int bx, int by, int cx, int cy,
                                          int ox, int oy, int r);
        query_t q;
        q.ax = to_coord(ax);
        q.ay = to_coord(ay);
        q.bx = to_coord(bx);
        q.by = to_coord(by);
        q.cx = to_coord(cx);
        q.cy = to_coord(cy);
        q.ox = to_coord(ox);
        q.oy = to_coord(oy);
        q.r  = r[RAD_W-1:0];
        return q;
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     kind, span, dx, dy, len, rad, t, k;
        int     px[4];
        int     py[4];
        bit     swap_xy, neg_x, neg_y;
        kind = $urandom_range(99);
        if (kind < 25)
        begin
            q.ax = COORD_W'($urandom);
            q.ay = COORD_W'($urandom);
            q.bx = COORD_W'($urandom);
            q.by = COORD_W'($urandom);
            q.cx = COORD_W'($urandom);
            q.cy = COORD_W'($urandom);
            q.ox = COORD_W'($urandom);
            q.oy = COORD_W'($urandom);
            q.r  = RAD_W'($urandom);
            return q;
        end
        if (kind >= 95)
        begin
            q.ax = pick_extreme();
            q.ay = pick_extreme();
            q.bx = pick_extreme();
            q.by = pick_extreme();
            q.cx = pick_extreme();
            q.cy = pick_extreme();
            q.ox = pick_extreme();
            q.oy = pick_extreme();
            q.r  = ($urandom_range(1) == 0) ? 15'h7fff : 15'($urandom_range(1));
            return q;
        end
        // The remaining kinds are built around the origin, then turned and moved.
        if (kind < 60)
        begin
            span = 16 << (4 * $urandom_range(2));
            for (k = 0; k < 4; k++)
            begin
                px[k] = sym(k == 3 ? 2 * span : span);
                py[k] = sym(k == 3 ? 2 * span : span);
            end
            rad = $urandom_range(2 * span);
        end
        else if (kind < 70)
        begin
            // Collinear or repeated vertices.
            dx    = sym(300);
            dy    = sym(300);
            px[0] = sym(100);
            py[0] = sym(100);
            for (k = 1; k < 4; k++)
            begin
                t     = sym(4);
                px[k] = px[0] + t * dx;
                py[k] = py[0] + t * dy;
            end
            if ($urandom_range(1))
            begin
                px[3] += sym(600);
                py[3] += sym(600);
            end
            rad = $urandom_range(1) ? 0 : $urandom_range(400);
        end
        else if (kind < 85)
        begin
            // Circle touching edge a-b from outside, missing it by one step, or crossing it by one.
            len   = $urandom_range(3000, 1);
            rad   = $urandom_range(3000);
            px[0] = 0;
            py[0] = 0;
            px[1] = len;
            py[1] = 0;
            px[2] = $urandom_range(len);
            py[2] = $urandom_range(3000, 1);
            px[3] = $urandom_range(len);
            py[3] = -rad + sym(1);
        end
        else
        begin
            for (k = 0; k < 3; k++)
            begin
                px[k] = sym(256);
                py[k] = sym(256);
            end
            k = $urandom_range(2);
            case ($urandom_range(2))
                0:
                begin
                    px[3] = px[k];
                    py[3] = py[k];
                end
                1:
                begin
                    px[3] = (px[k] + px[(k + 1) % 3]) / 2;
                    py[3] = (py[k] + py[(k + 1) % 3]) / 2;
                end
                default:
                begin
                    px[3] = sym(300);
                    py[3] = sym(300);
                end
            endcase
            rad = $urandom_range(1);
        end
        swap_xy = 1'($urandom_range(1));
        neg_x   = 1'($urandom_range(1));
        neg_y   = 1'($urandom_range(1));
        dx      = sym(30000);
        dy      = sym(30000);
        for (k = 0; k < 4; k++)
        begin
            if (swap_xy)
            begin
                t     = px[k];
                px[k] = py[k];
                py[k] = t;
            end
            px[k] = (neg_x ? -px[k] : px[k]) + dx;
            py[k] = (neg_y ? -py[k] : py[k]) + dy;
        end
        if (rad > 32767)
            rad = 32767;
        return make_query(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3], rad);
    endfunction

    task automatic drive_fields(input query_t q);
        vertex_a_x <= q.ax;
        vertex_a_y <= q.ay;
        vertex_b_x <= q.bx;
        vertex_b_y <= q.by;
        vertex_c_x <= q.cx;
        vertex_c_y <= q.cy;
        center_x   <= q.ox;
        center_y   <= q.oy;
        radius     <= q.r;
    endtask

    task automatic send_query(input query_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            drive_fields(random_query());
        end
        @(negedge clk);
        drive_fields(q);
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    initial
    begin
        query_t directed[$];
        int     phase, n;
        rst_n      = 1'b0;
        start      = 1'b0;
        vertex_a_x = '0;
        vertex_a_y = '0;
        vertex_b_x = '0;
        vertex_b_y = '0;
        vertex_c_x = '0;
        vertex_c_y = '0;
        center_x   = '0;
        center_y   = '0;
        radius     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767));
        directed.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                      -32768, -32768, 0));
        directed.push_back(make_query(-32768, -32768, 32767, -32768, 0, 32767, 0, 0, 0));
        directed.push_back(make_query(0, 0, 100, 0, 0, 100, -32768, 32767, 0));
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, -5, -5, 10));
        // Vertex exactly on the circle: not strictly inside, but the edge touches.
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, -10, 0, 10));
        // Tangent to the interior of an edge, then one step away from it.
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, 500, -20, 20));
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, 500, -21, 20));
        // Collinear triangle with the center on its line but past its ends, then off its line.
        directed.push_back(make_query(0, 0, 100, 100, 200, 200, 300, 300, 0));
        directed.push_back(make_query(0, 0, 100, 100, 200, 200, 0, 100, 0));
        // All vertices coincident.
        directed.push_back(make_query(50, 50, 50, 50, 50, 50, 60, 50, 0));
        // Zero-length edge with the center off the line.
        directed.push_back(make_query(0, 0, 0, 0, 1000, 0, 0, -30, 30));
        directed.push_back(make_query(0, 0, 0, 0, 1000, 0, 500, -30, 29));
        // Zero radius: on an edge, on a vertex, and just off a vertex.
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, 500, 0, 0));
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, 1000, 0, 0));
        directed.push_back(make_query(0, 0, 1000, 0, 0, 1000, 1001, 0, 0));
        directed.push_back(make_query(-300, -200, 400, -100, 0, 500, 10, 20, 3));
        directed.push_back(make_query(0, 0, 0, 1000, 1000, 0, 200, 200, 1));
        // Long diagonal edge with the center far off it.
        directed.push_back(make_query(-32768, -32768, 32767, 32767, -32768, 32767,
                                      32767, -32768, 32767));
        directed.push_back(make_query(-32768, -32768, 32767, 32767, -32768, 32767,
                                      32767, -32768, 23170));
        directed.push_back(make_query(-1, -1, -1000, -1, -1, -1000, 1, 1, 2));
        foreach (directed[i])
            send_query(directed[i]);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:       idle_pct = 64;
                2:       idle_pct = 21;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < NUM_RANDOM / NUM_PHASES; n++)
                send_query(random_query());
            if (phase == 1)
            begin
                // Hold the sender off until every outstanding transfer is back.
                @(negedge clk);
                start <= 1'b0;
                while (pending != 0)
                    @(posedge clk);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS triangle_circle_intersect");
        else
            $display("FAIL triangle_circle_intersect");
        $finish;
    end

endmodule

>>> sim.f
rtl/tci_pkg.sv
rtl/tci_edge.sv
rtl/triangle_circle_intersect.sv
verif/tci_checker.sv
verif/tb_triangle_circle_intersect.sv
